// ===== rtl/core/vnl_pkg.sv =====
`default_nettype none

package vnl_pkg;

  // fixed field widths
  localparam int ROW_BITS      = 64;
  localparam int RULE_BITS     = 5;
  localparam int WIDTH_BITS    = 7;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 7;

  // default number of columns built
  localparam int MAX_WIDTH_DEF = 64;

  // result queue
  localparam int QDEPTH    = 3;
  localparam int QCNT_BITS = 2;

  // reset rule B13/S13 and full row width
  localparam logic [RULE_BITS-1:0]  BIRTH_RST   = 5'd10;
  localparam logic [RULE_BITS-1:0]  SURVIVE_RST = 5'd10;
  localparam logic [WIDTH_BITS-1:0] WIDTH_RST   = 7'd64;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_BIRTH   = 2'd0,
    REG_SURVIVE = 2'd1,
    REG_WIDTH   = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [RULE_BITS-1:0] birth;
    logic [RULE_BITS-1:0] survive;
  } vnl_rule_t;

  // per-cycle control broadcast along the cell row
  typedef struct packed {
    logic load;  // row word accepted this cycle
    logic pend;  // a pending row takes part (held and not cut by a top row)
  } vnl_ctl_t;

  typedef struct packed {
    logic [ROW_BITS-1:0] next_row;
    logic                last_of_run;
    logic                grid_done;
  } vnl_word_t;

endpackage

`default_nettype wire

// ===== rtl/core/vnl_cell.sv =====
`default_nettype none

module vnl_cell (
  input  wire                     clk,
  input  wire vnl_pkg::vnl_ctl_t  ctl,
  input  wire vnl_pkg::vnl_rule_t rule,
  input  wire                     use_col,
  input  wire                     din,
  input  wire                     din_w,
  input  wire                     din_e,
  input  wire                     cen_w,
  input  wire                     cen_e,
  output logic                    din_m,
  output logic                    cen_m,
  output logic                    res_mid,
  output logic                    res_flush
);

  logic       above;
  logic       centre;
  logic       above_m;
  logic       above_f;
  logic [2:0] k_mid;
  logic [2:0] k_flush;
  logic [vnl_pkg::RULE_BITS-1:0] sel_mid;
  logic [vnl_pkg::RULE_BITS-1:0] sel_flush;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      above  <= ctl.pend & centre;
      centre <= din;
    end
  end

  assign din_m   = din & use_col;
  assign cen_m   = centre & use_col;
  assign above_m = above & use_col;
  // row above the flushed row is the pending row, if any
  assign above_f = ctl.pend & cen_m;

  assign k_mid   = {2'b00, above_m} + {2'b00, din_m} + {2'b00, cen_w} + {2'b00, cen_e};
  assign k_flush = {2'b00, above_f} + {2'b00, din_w} + {2'b00, din_e};

  assign sel_mid   = cen_m ? rule.survive : rule.birth;
  assign sel_flush = din_m ? rule.survive : rule.birth;

  assign res_mid   = use_col & sel_mid[k_mid];
  assign res_flush = use_col & sel_flush[k_flush];

endmodule

`default_nettype wire

// ===== rtl/core/vnl_outq.sv =====
`default_nettype none

module vnl_outq (
  input  wire                     clk,
  input  wire                     rst,
  input  wire [1:0]               npush,
  input  wire vnl_pkg::vnl_word_t w0,
  input  wire vnl_pkg::vnl_word_t w1,
  input  wire                     pop,
  output logic                    nonempty,
  output logic                    nearly_full,
  output vnl_pkg::vnl_word_t      head
);

  logic [vnl_pkg::QCNT_BITS-1:0] count;
  logic [vnl_pkg::QCNT_BITS-1:0] count_next;
  logic [vnl_pkg::QCNT_BITS-1:0] base;
  vnl_pkg::vnl_word_t q      [vnl_pkg::QDEPTH];
  vnl_pkg::vnl_word_t q_next [vnl_pkg::QDEPTH];

  always_comb begin
    base = count - {{(vnl_pkg::QCNT_BITS-1){1'b0}}, pop};
    for (int i = 0; i < vnl_pkg::QDEPTH; i++) begin
      if (pop && i < vnl_pkg::QDEPTH - 1) begin
        q_next[i] = q[i+1];
      end else begin
        q_next[i] = q[i];
      end
      if (npush != 2'd0 && vnl_pkg::QCNT_BITS'(i) == base) begin
        q_next[i] = w0;
      end else if (npush == 2'd2 && vnl_pkg::QCNT_BITS'(i) == base + 1'b1) begin
        q_next[i] = w1;
      end
    end
    count_next = base + npush;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < vnl_pkg::QDEPTH; i++) begin
      q[i] <= q_next[i];
    end
  end

  assign nonempty    = (count != '0);
  // room for two words is needed before a row word is taken
  assign nearly_full = (count >= vnl_pkg::QCNT_BITS'(vnl_pkg::QDEPTH - 1));
  assign head        = q[0];

endmodule

`default_nettype wire

// ===== rtl/core/von_neumann_life_row_step_top.sv =====
// channel  | valid     | stall     | word
// row in   | row_valid | row_stall | row_cells, row_first, row_last
// result   | res_valid | res_stall | next_row, last_of_run, grid_done
// config   | cfg_we    | -         | cfg_index, cfg_data
//
// a row word is taken every cycle while row_stall is low;
// each yields zero, one or two result words, and a bottom row adds its flush word
// result words are registered in the result queue before they appear at the result side
// row_stall rises while the three-entry result queue has room for less than two words
// synchronous reset restores the B13/S13 rule, full width and an empty pipeline
`default_nettype none

module von_neumann_life_row_step_top #(
  parameter int MAX_WIDTH = vnl_pkg::MAX_WIDTH_DEF
) (
  input  wire                               clk,
  input  wire                               rst,
  // configuration
  input  wire                               cfg_we,
  input  wire [vnl_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  wire [vnl_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  // row words in
  input  wire                               row_valid,
  output logic                              row_stall,
  input  wire [vnl_pkg::ROW_BITS-1:0]       row_cells,
  input  wire                               row_first,
  input  wire                               row_last,
  // result words out
  output logic                              res_valid,
  input  wire                               res_stall,
  output logic [vnl_pkg::ROW_BITS-1:0]      next_row,
  output logic                              last_of_run,
  output logic                              grid_done
);

  // configuration registers
  vnl_pkg::vnl_rule_t                rule;
  logic [vnl_pkg::WIDTH_BITS-1:0]    row_width;

  always_ff @(posedge clk) begin
    if (rst) begin
      rule.birth   <= vnl_pkg::BIRTH_RST;
      rule.survive <= vnl_pkg::SURVIVE_RST;
      row_width    <= vnl_pkg::WIDTH_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        vnl_pkg::REG_BIRTH:   rule.birth   <= cfg_data[vnl_pkg::RULE_BITS-1:0];
        vnl_pkg::REG_SURVIVE: rule.survive <= cfg_data[vnl_pkg::RULE_BITS-1:0];
        vnl_pkg::REG_WIDTH:   row_width    <= cfg_data;
        default: ;
      endcase
    end
  end

  // handshake and pending-row flag
  logic              accept;
  logic              centre_valid;
  logic              q_nonempty;
  logic              q_nearly_full;
  logic              pop;
  vnl_pkg::vnl_ctl_t ctl;

  assign accept   = row_valid & ~row_stall;
  assign ctl.load = accept;
  // a top row drops whatever was pending
  assign ctl.pend = centre_valid & ~row_first;

  always_ff @(posedge clk) begin
    if (rst) begin
      centre_valid <= 1'b0;
    end else if (accept) begin
      // a bottom row flushes itself, leaving nothing pending
      centre_valid <= ~row_last;
    end
  end

  // row of cells: each column holds its bits of the row above and the pending
  // row, and trades its masked bits with its east and west neighbors
  logic [vnl_pkg::ROW_BITS-1:0] res_mid;
  logic [vnl_pkg::ROW_BITS-1:0] res_flush;
  logic [MAX_WIDTH-1:0]         din_m;
  logic [MAX_WIDTH-1:0]         cen_m;

  for (genvar c = 0; c < vnl_pkg::ROW_BITS; c++) begin : g_col
    if (c < MAX_WIDTH) begin : g_cell
      logic use_col;
      logic din_w;
      logic din_e;
      logic cen_w;
      logic cen_e;

      assign use_col = (vnl_pkg::WIDTH_BITS'(c) < row_width);

      if (c == 0) begin : g_west_edge
        assign din_w = 1'b0;
        assign cen_w = 1'b0;
      end else begin : g_west
        assign din_w = din_m[c-1];
        assign cen_w = cen_m[c-1];
      end

      if (c == MAX_WIDTH - 1) begin : g_east_edge
        assign din_e = 1'b0;
        assign cen_e = 1'b0;
      end else begin : g_east
        assign din_e = din_m[c+1];
        assign cen_e = cen_m[c+1];
      end

      vnl_cell u_cell (
        .clk       (clk),
        .ctl       (ctl),
        .rule      (rule),
        .use_col   (use_col),
        .din       (row_cells[c]),
        .din_w     (din_w),
        .din_e     (din_e),
        .cen_w     (cen_w),
        .cen_e     (cen_e),
        .din_m     (din_m[c]),
        .cen_m     (cen_m[c]),
        .res_mid   (res_mid[c]),
        .res_flush (res_flush[c])
      );
    end else begin : g_unused
      // columns beyond the built row are always dead
      assign res_mid[c]   = 1'b0;
      assign res_flush[c] = 1'b0;
    end
  end

  // result words for this row word: the pending row first, then the flush
  vnl_pkg::vnl_word_t w_mid;
  vnl_pkg::vnl_word_t w_flush;
  vnl_pkg::vnl_word_t w0;
  vnl_pkg::vnl_word_t head;
  logic [1:0]         npush;

  assign w_mid.next_row      = res_mid;
  assign w_mid.last_of_run   = ~row_last;
  assign w_mid.grid_done     = 1'b0;
  assign w_flush.next_row    = res_flush;
  assign w_flush.last_of_run = 1'b1;
  assign w_flush.grid_done   = 1'b1;

  assign w0    = ctl.pend ? w_mid : w_flush;
  assign npush = accept ? ({1'b0, ctl.pend} + {1'b0, row_last}) : 2'd0;
  assign pop   = q_nonempty & ~res_stall;

  vnl_outq u_outq (
    .clk         (clk),
    .rst         (rst),
    .npush       (npush),
    .w0          (w0),
    .w1          (w_flush),
    .pop         (pop),
    .nonempty    (q_nonempty),
    .nearly_full (q_nearly_full),
    .head        (head)
  );

  assign row_stall   = q_nearly_full;
  assign res_valid   = q_nonempty;
  assign next_row    = head.next_row;
  assign last_of_run = head.last_of_run;
  assign grid_done   = head.grid_done;

endmodule

`default_nettype wire

// ===== rtl/core/vnl_check.sv =====
`default_nettype none

module vnl_check (
  input wire clk,
  input wire rst,
  input wire row_valid,
  input wire row_stall,
  input wire row_last,
  input wire res_valid,
  input wire res_stall,
  input wire last_of_run,
  input wire grid_done
);

  // a stalled result word is not withdrawn
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid)
    else $error("result word dropped while stalled");

  // the bottom row result is always the final word of its run
  a_done_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && grid_done |-> last_of_run)
    else $error("grid_done without last_of_run");

  // after a bottom row is taken, a result word is always valid on the next cycle
  a_flush: assert property (@(posedge clk) disable iff (rst)
    row_valid && !row_stall && row_last |=> res_valid)
    else $error("bottom row produced no result");

  // reset leaves the block empty and open
  a_reset: assert property (@(posedge clk)
    rst |=> !res_valid && !row_stall)
    else $error("block not empty after reset");

endmodule

bind von_neumann_life_row_step_top vnl_check u_vnl_check (
  .clk         (clk),
  .rst         (rst),
  .row_valid   (row_valid),
  .row_stall   (row_stall),
  .row_last    (row_last),
  .res_valid   (res_valid),
  .res_stall   (res_stall),
  .last_of_run (last_of_run),
  .grid_done   (grid_done)
);

`default_nettype wire
